### sv/bdar_pkg.sv
package bdar_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 16;

  localparam int NOW_W    = 32;
  localparam int HOLD_W   = 16;
  localparam int DEB_W    = 16;
  localparam int IPER_W   = 15;
  localparam int PERIOD_W = 16;
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 3;

  localparam int unsigned TICK_MS     = 10;
  localparam int unsigned THRESH_FAST = 750;
  localparam int unsigned THRESH_MID  = 500;
  localparam int unsigned THRESH_SLOW = 200;
  localparam int unsigned PERIOD_FAST = 1;
  localparam int unsigned PERIOD_MID  = 10;
  localparam int unsigned PERIOD_SLOW = 30;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 16'd70;
  localparam logic [IPER_W-1:0] PERIOD_RESET   = 15'd100;

  typedef enum logic {
    REG_DEBOUNCE = 1'b0,
    REG_PERIOD   = 1'b1
  } reg_idx_t;

  // a zero period counts as one
  function automatic logic [PERIOD_W-1:0] start_period(input logic [IPER_W-1:0] init);
    logic [PERIOD_W-1:0] p;
    p = PERIOD_W'(init);
    if (init == '0) begin
      p = PERIOD_W'(1);
    end
    return p;
  endfunction

endpackage

### sv/button_debounce_autorepeat_unit.sv
// path (2-deep): an accepted item goes into the input register, then its state update goes
//   into the result register
// throughput: one item per cycle; while a result waits the input register takes one more item,
//   then in_ready stays low until the result is taken
// reset (rst_n low, synchronous): button released, counters at -1, debounce 70 ms,
//   repeat period 100, input register and result register emptied
module button_debounce_autorepeat_unit #(
  parameter int TIME_BITS  = bdar_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = bdar_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_pin_active,
  input  logic [bdar_pkg::NOW_W-1:0]    in_now_ms,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_event_res,
  output logic                          out_held,
  output logic signed [bdar_pkg::HOLD_W-1:0] out_hold_count,

  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bdar_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [bdar_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [bdar_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import bdar_pkg::*;

  localparam int CMP_W = (COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W;
  localparam logic signed [COUNT_BITS-1:0] CNT_MAX  = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_IDLE = '1;

  // configuration
  logic [DEB_W-1:0]  debounce_ms_r;
  logic [IPER_W-1:0] init_period_r;
  reg_idx_t          cfg_idx;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_idx)
      REG_DEBOUNCE: cfg_prdata = CFG_DW'(debounce_ms_r);
      REG_PERIOD:   cfg_prdata = CFG_DW'(init_period_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= DEBOUNCE_RESET;
      init_period_r <= PERIOD_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEBOUNCE: debounce_ms_r <= cfg_pwdata[DEB_W-1:0];
        REG_PERIOD:   init_period_r <= cfg_pwdata[IPER_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                 s1_vld_r;
  logic                 s1_active_r;
  logic [TIME_BITS-1:0] s1_now_r;
  logic                 s1_fire;

  assign s1_fire  = s1_vld_r && (!out_valid || out_ready);
  assign in_ready = !s1_vld_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_active_r <= in_pin_active;
      s1_now_r    <= TIME_BITS'(in_now_ms);
    end
  end

  // button state
  logic                         held_r, held_nxt;
  logic [TIME_BITS-1:0]         last_active_r, last_active_nxt;
  logic [TIME_BITS-1:0]         last_tick_r, last_tick_nxt;
  logic signed [COUNT_BITS-1:0] hold_r, hold_nxt;
  logic signed [COUNT_BITS-1:0] rep_r, rep_nxt;
  logic [PERIOD_W-1:0]          period_r, period_nxt;
  logic                         event_nxt;

  logic [TIME_BITS-1:0]         tick_diff, idle_diff;
  logic signed [COUNT_BITS-1:0] hold_inc, rep_inc;
  logic                         tick, rep_due;

  assign tick_diff = s1_now_r - last_tick_r;
  assign idle_diff = s1_now_r - last_active_r;
  assign tick      = tick_diff > TIME_BITS'(TICK_MS);

  always_comb begin
    hold_inc = hold_r;
    rep_inc  = rep_r;
    if (tick) begin
      if (hold_r < CNT_MAX) hold_inc = hold_r + COUNT_BITS'(1);
      if (rep_r < CNT_MAX)  rep_inc  = rep_r + COUNT_BITS'(1);
    end
  end

  assign rep_due = !rep_inc[COUNT_BITS-1] &&
                   (CMP_W'($unsigned(rep_inc)) >= CMP_W'(period_r));

  always_comb begin
    held_nxt        = held_r;
    last_active_nxt = last_active_r;
    last_tick_nxt   = last_tick_r;
    hold_nxt        = hold_r;
    rep_nxt         = rep_r;
    period_nxt      = period_r;
    event_nxt       = 1'b0;
    if (s1_active_r) begin
      held_nxt        = 1'b1;
      last_active_nxt = s1_now_r;
      hold_nxt        = hold_inc;
      rep_nxt         = rep_inc;
      if (tick) last_tick_nxt = s1_now_r;
      if (rep_due) begin
        event_nxt = 1'b1;
        rep_nxt   = '0;
      end
      // acceleration steps by hold count, signed so an idle count of -1 stays below
      if (hold_inc > $signed(COUNT_BITS'(THRESH_FAST))) begin
        period_nxt = PERIOD_W'(PERIOD_FAST);
      end else if (hold_inc > $signed(COUNT_BITS'(THRESH_MID))) begin
        period_nxt = PERIOD_W'(PERIOD_MID);
      end else if (hold_inc > $signed(COUNT_BITS'(THRESH_SLOW))) begin
        period_nxt = PERIOD_W'(PERIOD_SLOW);
      end
    end else if (held_r && (idle_diff > TIME_BITS'(debounce_ms_r))) begin
      event_nxt  = 1'b1;
      held_nxt   = 1'b0;
      period_nxt = start_period(init_period_r);
      hold_nxt   = CNT_IDLE;
      rep_nxt    = CNT_IDLE;
    end
  end

  // result register
  logic                     out_valid_r;
  logic                     out_event_r;
  logic                     out_held_r;
  logic signed [HOLD_W-1:0] out_hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r        <= 1'b0;
      last_active_r <= '0;
      last_tick_r   <= '0;
      hold_r        <= CNT_IDLE;
      rep_r         <= CNT_IDLE;
      period_r      <= start_period(PERIOD_RESET);
      out_valid_r   <= 1'b0;
    end else begin
      if (s1_fire) begin
        held_r        <= held_nxt;
        last_active_r <= last_active_nxt;
        last_tick_r   <= last_tick_nxt;
        hold_r        <= hold_nxt;
        rep_r         <= rep_nxt;
        period_r      <= period_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r   <= 1'b0;
      end
    end
    if (s1_fire) begin
      out_event_r <= event_nxt;
      out_held_r  <= held_nxt;
      out_hold_r  <= HOLD_W'(hold_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = out_event_r;
  assign out_held       = out_held_r;
  assign out_hold_count = out_hold_r;

  // a released button keeps both counters idle
  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !held_r |-> (hold_r == CNT_IDLE) && (rep_r == CNT_IDLE))
    else $error("counters not idle while released");

  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    period_r != '0)
    else $error("repeat period is zero");

  a_out_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_held_r |-> out_hold_r == '1)
    else $error("released result with nonidle hold count");

  a_stall_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_valid_r && !out_ready |=> s1_vld_r && $stable(s1_now_r))
    else $error("pending item lost during output stall");

  a_state_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(hold_r) && $stable(held_r) && $stable(period_r))
    else $error("button state changed without an item");

endmodule
